>>> rtl/skq_pkg.sv
// ----------------------------------------------------------------------------
// skq_pkg: shared types and constants for the sprite key sorter
// Field widths of one entry, the packed entry layout and the default capacity.
// ----------------------------------------------------------------------------
`default_nettype none

package skq_pkg;

  // Widths of the fields of one entry.
  localparam int KEY_W = 16;
  localparam int TAG_W = 10;

  // One stored entry holds the key above the tag.
  localparam int ENTRY_W = KEY_W + TAG_W;

  // Default number of entries held per batch.
  localparam int SKQ_DEPTH = 64;

  typedef logic [ENTRY_W-1:0] entry_t;

endpackage

`default_nettype wire

>>> rtl/skq_ram.sv
// ----------------------------------------------------------------------------
// skq_ram: generic synchronous RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module skq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read; a read of the address being written returns old data.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> rtl/sprite_key_quicksort.sv
// ----------------------------------------------------------------------------
// sprite_key_quicksort: batch sorter of sprite entries by vertical key
// Loads entries, sorts them by quicksort with a Lomuto partition and emits them.
// ----------------------------------------------------------------------------
// Entries are taken one beat per cycle while busy is low; the entry with
// last_in set closes the batch. Up to DEPTH entries are kept, later ones are
// dropped and every result of that batch then carries overflow. After the
// closing beat busy stays high while the batch is sorted in ascending signed
// key order and emitted, one result per cycle on strobe; the receiver cannot
// stall, so results must be taken as they come. The sort runs on the entry
// RAM, which has one write port: each range is popped from the stack, its
// pivot read and its elements scanned; each scanned element is read and
// compared, and one that is swapped takes a further write. The pivot is then
// moved into place and the subranges pushed. The final beat is on the ports
// in the first cycle with busy low.
// ----------------------------------------------------------------------------
`default_nettype none

module sprite_key_quicksort #(
  parameter int DEPTH = skq_pkg::SKQ_DEPTH
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic signed [skq_pkg::KEY_W-1:0]  y_key,
  input  wire logic        [skq_pkg::TAG_W-1:0]  tag,
  input  wire logic                              last_in,
  output logic                                   strobe,
  output logic signed      [skq_pkg::KEY_W-1:0]  sorted_key,
  output logic             [skq_pkg::TAG_W-1:0]  sorted_tag,
  output logic                                   last_out,
  output logic                                   overflow
);

  import skq_pkg::*;

  // Index width into the stores, and count width that can hold DEPTH itself.
  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = 2 * IW;

  // Sequencer states.
  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_INIT     = 4'd1;
  localparam logic [3:0] S_POP      = 4'd2;
  localparam logic [3:0] S_RANGE    = 4'd3;
  localparam logic [3:0] S_PIVOT    = 4'd4;
  localparam logic [3:0] S_SCAN_RD  = 4'd5;
  localparam logic [3:0] S_SCAN_CMP = 4'd6;
  localparam logic [3:0] S_SCAN_WR2 = 4'd7;
  localparam logic [3:0] S_FIN_RD   = 4'd8;
  localparam logic [3:0] S_FIN_W1   = 4'd9;
  localparam logic [3:0] S_FIN_W2   = 4'd10;
  localparam logic [3:0] S_PUSH1    = 4'd11;
  localparam logic [3:0] S_PUSH2    = 4'd12;
  localparam logic [3:0] S_EMIT     = 4'd13;

  logic [3:0]       state;
  logic [CW-1:0]    count;
  logic             ovf_seen;
  logic [CW-1:0]    sp;
  logic [IW-1:0]    lo;
  logic [IW-1:0]    hi;
  logic [IW-1:0]    slot;
  logic [IW-1:0]    j;
  logic [KEY_W-1:0] pivot;
  entry_t           e_hi;
  entry_t           e_tmp;
  logic [CW-1:0]    k;

  // Memory port signals.
  logic          ent_we;
  logic [IW-1:0] ent_waddr;
  entry_t        ent_wdata;
  logic [IW-1:0] ent_raddr_a;
  logic [IW-1:0] ent_raddr_b;
  entry_t        ent_rdata_a;
  entry_t        ent_rdata_b;
  logic          stk_we;
  logic [IW-1:0] stk_waddr;
  logic [SW-1:0] stk_wdata;
  logic [IW-1:0] stk_raddr;
  logic [SW-1:0] stk_rdata;

  // Decoded values used by several states.
  logic [IW-1:0]    pop_lo;
  logic [IW-1:0]    pop_hi;
  logic [KEY_W-1:0] key_j;
  logic             less;
  logic [IW-1:0]    j_inc;
  logic             push_room;
  logic             push_right;
  logic             push_left;
  logic [CW-1:0]    k_inc;

  assign pop_lo     = stk_rdata[IW-1:0];
  assign pop_hi     = stk_rdata[SW-1:IW];
  assign key_j      = ent_rdata_a[ENTRY_W-1 -: KEY_W];
  assign less       = $signed(key_j) < $signed(pivot);
  assign j_inc      = j + IW'(1);
  assign push_room  = sp < CW'(DEPTH);
  assign push_right = ({1'b0, slot} + (IW+1)'(1)) < {1'b0, hi};
  assign push_left  = {1'b0, slot} > ({1'b0, lo} + (IW+1)'(1));
  assign k_inc      = k + CW'(1);

  // Entry store; two copies written alike give two read ports.
  skq_ram #(.WIDTH(ENTRY_W), .DEPTH(DEPTH)) u_ent_a (
    .clk   (clk),
    .we    (ent_we),
    .waddr (ent_waddr),
    .wdata (ent_wdata),
    .raddr (ent_raddr_a),
    .rdata (ent_rdata_a)
  );

  skq_ram #(.WIDTH(ENTRY_W), .DEPTH(DEPTH)) u_ent_b (
    .clk   (clk),
    .we    (ent_we),
    .waddr (ent_waddr),
    .wdata (ent_wdata),
    .raddr (ent_raddr_b),
    .rdata (ent_rdata_b)
  );

  // Range stack, each word holding the high index above the low index.
  skq_ram #(.WIDTH(SW), .DEPTH(DEPTH)) u_stack (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (stk_wdata),
    .raddr (stk_raddr),
    .rdata (stk_rdata)
  );

  // Memory addresses and writes for each state.
  always_comb begin
    ent_we      = 1'b0;
    ent_waddr   = slot;
    ent_wdata   = e_hi;
    ent_raddr_a = j;
    ent_raddr_b = slot;
    stk_we      = 1'b0;
    stk_waddr   = sp[IW-1:0];
    stk_wdata   = {hi, slot + IW'(1)};
    stk_raddr   = sp[IW-1:0] - IW'(1);
    unique case (state)
      S_IDLE: begin
        ent_we    = start && (count < CW'(DEPTH));
        ent_waddr = count[IW-1:0];
        ent_wdata = {y_key, tag};
      end
      S_INIT: begin
        stk_we    = count > CW'(1);
        stk_waddr = '0;
        stk_wdata = {IW'(count - CW'(1)), IW'(0)};
      end
      S_RANGE: begin
        ent_raddr_a = pop_hi;
      end
      S_SCAN_CMP: begin
        ent_we    = less;
        ent_waddr = slot;
        ent_wdata = ent_rdata_a;
      end
      S_SCAN_WR2: begin
        ent_we    = 1'b1;
        ent_waddr = j;
        ent_wdata = e_tmp;
      end
      S_FIN_W1: begin
        ent_we    = 1'b1;
        ent_waddr = slot;
        ent_wdata = e_hi;
      end
      S_FIN_W2: begin
        ent_we    = 1'b1;
        ent_waddr = hi;
        ent_wdata = e_tmp;
      end
      S_PUSH1: begin
        stk_we    = push_right && push_room;
        stk_wdata = {hi, slot + IW'(1)};
      end
      S_PUSH2: begin
        stk_we    = push_left && push_room;
        stk_wdata = {slot - IW'(1), lo};
      end
      S_EMIT: begin
        ent_raddr_a = k[IW-1:0];
      end
      default: begin
      end
    endcase
  end

  // Sequencer: load, partition ranges from the stack, then emit.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      ovf_seen <= 1'b0;
      sp       <= '0;
      k        <= '0;
      strobe   <= 1'b0;
      last_out <= 1'b0;
      overflow <= 1'b0;
    end else begin
      strobe <= (state == S_EMIT);
      unique case (state)
        S_IDLE: begin
          if (start) begin
            if (count < CW'(DEPTH)) begin
              count <= count + CW'(1);
            end else begin
              ovf_seen <= 1'b1;
            end
            if (last_in) begin
              state <= S_INIT;
            end
          end
        end
        S_INIT: begin
          k <= '0;
          if (count > CW'(1)) begin
            sp    <= CW'(1);
            state <= S_POP;
          end else begin
            sp    <= '0;
            state <= S_EMIT;
          end
        end
        S_POP: begin
          if (sp == '0) begin
            k     <= '0;
            state <= S_EMIT;
          end else begin
            sp    <= sp - CW'(1);
            state <= S_RANGE;
          end
        end
        S_RANGE: begin
          if (pop_lo >= pop_hi || CW'(pop_hi) >= count) begin
            state <= S_POP;
          end else begin
            lo    <= pop_lo;
            hi    <= pop_hi;
            slot  <= pop_lo;
            j     <= pop_lo;
            state <= S_PIVOT;
          end
        end
        S_PIVOT: begin
          pivot <= ent_rdata_a[ENTRY_W-1 -: KEY_W];
          e_hi  <= ent_rdata_a;
          state <= S_SCAN_RD;
        end
        S_SCAN_RD: begin
          state <= S_SCAN_CMP;
        end
        S_SCAN_CMP: begin
          if (less) begin
            e_tmp <= ent_rdata_b;
            state <= S_SCAN_WR2;
          end else begin
            j     <= j_inc;
            state <= (j_inc == hi) ? S_FIN_RD : S_SCAN_RD;
          end
        end
        S_SCAN_WR2: begin
          slot  <= slot + IW'(1);
          j     <= j_inc;
          state <= (j_inc == hi) ? S_FIN_RD : S_SCAN_RD;
        end
        S_FIN_RD: begin
          state <= S_FIN_W1;
        end
        S_FIN_W1: begin
          e_tmp <= ent_rdata_b;
          state <= S_FIN_W2;
        end
        S_FIN_W2: begin
          state <= S_PUSH1;
        end
        S_PUSH1: begin
          if (push_right && push_room) begin
            sp <= sp + CW'(1);
          end
          state <= S_PUSH2;
        end
        S_PUSH2: begin
          if (push_left && push_room) begin
            sp <= sp + CW'(1);
          end
          state <= S_POP;
        end
        S_EMIT: begin
          last_out <= (k_inc == count);
          overflow <= ovf_seen;
          k        <= k_inc;
          if (k_inc == count) begin
            count    <= '0;
            ovf_seen <= 1'b0;
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign busy       = (state != S_IDLE);
  assign sorted_key = ent_rdata_a[ENTRY_W-1 -: KEY_W];
  assign sorted_tag = ent_rdata_a[TAG_W-1:0];

`ifndef NO_ASSERTIONS
  // A result beat only follows a cycle of emission.
  a_strobe_from_emit: assert property (@(posedge clk) disable iff (rst)
    strobe |-> $past(state) == S_EMIT)
    else $error("result beat without emission");

  // The last beat of a batch is followed by a cycle without a beat.
  a_last_ends_batch: assert property (@(posedge clk) disable iff (rst)
    strobe && last_out |=> !strobe)
    else $error("result beat right after the last beat");

  // The range stack never grows past its capacity.
  a_stack_bound: assert property (@(posedge clk) disable iff (rst)
    sp <= CW'(DEPTH))
    else $error("range stack overrun");

  // During the scan the store slot trails the scan index, which stays below the pivot.
  a_scan_order: assert property (@(posedge clk) disable iff (rst)
    state == S_SCAN_RD |-> (slot <= j) && (j < hi))
    else $error("partition indexes out of order");
`endif

endmodule

`default_nettype wire

>>> bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the sprite key batch sorter
// Feeds batches of keyed entries through the start/busy command port and
// checks every emitted beat against an in-bench Lomuto quicksort predictor.
// A short directed table comes first, then randomized batches of varied size
// and key shape, including a full batch and an overflowing one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import skq_pkg::*;

  // One emitted beat of a sorted batch.
  typedef struct packed {
    logic signed [KEY_W-1:0] key;
    logic        [TAG_W-1:0] tag;
    logic                    last;
    logic                    ovf;
  } sorted_beat_t;

  // One row of the directed table; exp_beat is used only where typed_exp is set.
  typedef struct packed {
    logic signed [KEY_W-1:0] key;
    logic        [TAG_W-1:0] tag;
    logic                    last;
    logic                    typed_exp;
    sorted_beat_t            exp_beat;
  } stim_row_t;

  // Shapes of key content within one random batch.
  typedef enum int {
    KEYS_ANY,
    KEYS_TIES,
    KEYS_RISING,
    KEYS_FALLING,
    KEYS_EXTREME
  } key_style_t;

  localparam int DIRECTED_ROWS = 22;
  localparam int RANDOM_ITEMS  = 338;

  logic                    clk = 1'b0;
  logic                    rst;
  logic                    start;
  logic                    busy;
  logic signed [KEY_W-1:0] y_key;
  logic        [TAG_W-1:0] tag;
  logic                    last_in;
  logic                    strobe;
  logic signed [KEY_W-1:0] sorted_key;
  logic        [TAG_W-1:0] sorted_tag;
  logic                    last_out;
  logic                    overflow;

  // Predictor state: entries held for the open batch and the range stack.
  logic signed [KEY_W-1:0] held_key [SKQ_DEPTH];
  logic        [TAG_W-1:0] held_tag [SKQ_DEPTH];
  int                      held_count;
  logic                    held_overflow;
  logic        [11:0]      range_stk [SKQ_DEPTH];
  int                      range_sp;

  sorted_beat_t sorted_beats_due [$];
  int           fail_count;

  // Directed stimulus: single-entry batches at the key extremes and around zero
  // carry their expected beat, the multi-entry batches are left to the predictor.
  stim_row_t directed_rows [DIRECTED_ROWS] = '{
    '{-16'sd32768, 10'd0,    1'b1, 1'b1, '{-16'sd32768, 10'd0,    1'b1, 1'b0}},
    '{ 16'sd32767, 10'd1023, 1'b1, 1'b1, '{ 16'sd32767, 10'd1023, 1'b1, 1'b0}},
    '{ 16'sd0,     10'h155,  1'b1, 1'b1, '{ 16'sd0,     10'h155,  1'b1, 1'b0}},
    '{-16'sd1,     10'h2AA,  1'b1, 1'b1, '{-16'sd1,     10'h2AA,  1'b1, 1'b0}},
    '{ 16'sd32767, 10'd1,    1'b0, 1'b0, '0},
    '{-16'sd32768, 10'd2,    1'b0, 1'b0, '0},
    '{ 16'sd0,     10'd3,    1'b1, 1'b0, '0},
    '{ 16'sd5,     10'd10,   1'b0, 1'b0, '0},
    '{ 16'sd5,     10'd11,   1'b0, 1'b0, '0},
    '{-16'sd1,     10'd12,   1'b0, 1'b0, '0},
    '{ 16'sd5,     10'd13,   1'b0, 1'b0, '0},
    '{-16'sd1,     10'd14,   1'b1, 1'b0, '0},
    '{-16'sd300,   10'd20,   1'b0, 1'b0, '0},
    '{-16'sd10,    10'd21,   1'b0, 1'b0, '0},
    '{ 16'sd10,    10'd22,   1'b0, 1'b0, '0},
    '{ 16'sd300,   10'd23,   1'b1, 1'b0, '0},
    '{ 16'sd300,   10'd30,   1'b0, 1'b0, '0},
    '{ 16'sd10,    10'd31,   1'b0, 1'b0, '0},
    '{-16'sd10,    10'd32,   1'b0, 1'b0, '0},
    '{-16'sd300,   10'd33,   1'b1, 1'b0, '0},
    '{ 16'sd7,     10'd40,   1'b0, 1'b0, '0},
    '{ 16'sd7,     10'd41,   1'b1, 1'b0, '0}
  };

  sprite_key_quicksort u_dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .y_key     (y_key),
    .tag       (tag),
    .last_in   (last_in),
    .strobe    (strobe),
    .sorted_key(sorted_key),
    .sorted_tag(sorted_tag),
    .last_out  (last_out),
    .overflow  (overflow)
  );

  always #1 clk = ~clk;

  // Append one expected beat at the tail of the queue.
  function automatic void queue_beat(sorted_beat_t b);
    sorted_beats_due = {sorted_beats_due, b};
  endfunction

  // Exchange two held entries, key and tag together.
  function automatic void swap_held(int a, int b);
    logic signed [KEY_W-1:0] k;
    logic        [TAG_W-1:0] t;
    k = held_key[a];
    t = held_tag[a];
    held_key[a] = held_key[b];
    held_tag[a] = held_tag[b];
    held_key[b] = k;
    held_tag[b] = t;
  endfunction

  // Push an index range; a full stack silently drops it.
  function automatic void push_range(int lo, int hi);
    if (range_sp < SKQ_DEPTH) begin
      range_stk[range_sp] = {hi[5:0], lo[5:0]};
      range_sp++;
    end
  endfunction

  // Lomuto partition around the last element; returns the pivot's final slot.
  function automatic int partition_range(int lo, int hi);
    logic signed [KEY_W-1:0] pivot;
    int slot;
    int j;
    pivot = held_key[hi];
    slot = lo;
    for (j = lo; j < hi; j++) begin
      if (held_key[j] < pivot) begin
        swap_held(slot, j);
        slot++;
      end
    end
    swap_held(slot, hi);
    return slot;
  endfunction

  // Iterative quicksort over the held entries, right range pushed first.
  function automatic void sort_held();
    logic [11:0] top;
    int lo;
    int hi;
    int p;
    range_sp = 0;
    if (held_count > 1) push_range(0, held_count - 1);
    while (range_sp > 0) begin
      range_sp--;
      top = range_stk[range_sp];
      lo = top[5:0];
      hi = top[11:6];
      if (lo >= hi || hi >= held_count) continue;
      p = partition_range(lo, hi);
      if (p + 1 < hi) push_range(p + 1, hi);
      if (p > lo + 1) push_range(lo, p - 1);
    end
  endfunction

  // Take one accepted entry; a closing entry queues the whole sorted batch.
  function automatic void absorb_entry(logic signed [KEY_W-1:0] key_in,
                                       logic [TAG_W-1:0] tag_in, logic last_flag);
    sorted_beat_t b;
    int k;
    if (held_count < SKQ_DEPTH) begin
      held_key[held_count] = key_in;
      held_tag[held_count] = tag_in;
      held_count++;
    end else begin
      held_overflow = 1'b1;
    end
    if (last_flag) begin
      sort_held();
      for (k = 0; k < held_count; k++) begin
        b.key  = held_key[k];
        b.tag  = held_tag[k];
        b.last = (k + 1 == held_count);
        b.ovf  = held_overflow;
        queue_beat(b);
      end
      held_count = 0;
      held_overflow = 1'b0;
    end
  endfunction

  // Idle gap before a beat: mostly none, some short, a few long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Key for position i of a random batch, shaped by the batch's style.
  function automatic logic signed [KEY_W-1:0] pick_key(key_style_t style, int i);
    int v;
    v = $urandom_range(0, 600);
    case (style)
      KEYS_TIES:    v = $urandom_range(0, 4) - 2;
      KEYS_RISING:  v = -30000 + i * 900 + v;
      KEYS_FALLING: v = 30000 - i * 900 - v;
      KEYS_EXTREME: begin
        case ($urandom_range(0, 4))
          0:       v = -32768;
          1:       v = -1;
          2:       v = 0;
          3:       v = 1;
          default: v = 32767;
        endcase
      end
      default:      v = $urandom;
    endcase
    return v[KEY_W-1:0];
  endfunction

  // Drive one entry and hold it until the block accepts the beat.
  task automatic send_entry(logic signed [KEY_W-1:0] key_in, logic [TAG_W-1:0] tag_in,
                            logic last_flag, bit no_idle);
    int gap;
    gap = no_idle ? 0 : pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    y_key   <= key_in;
    tag     <= tag_in;
    last_in <= last_flag;
    do @(posedge clk); while (busy);
    absorb_entry(key_in, tag_in, last_flag);
  endtask

  // Compare each result beat with the oldest expectation.
  always @(posedge clk) begin
    sorted_beat_t want;
    sorted_beat_t got;
    if (!rst && strobe) begin
      got = '{sorted_key, sorted_tag, last_out, overflow};
      if (sorted_beats_due.size() == 0) begin
        if (fail_count < 10)
          $display("%0t: unexpected beat key %0d tag %0d last %0b ovf %0b", $realtime,
                   got.key, got.tag, got.last, got.ovf);
        fail_count++;
      end else begin
        want = sorted_beats_due.pop_front();
        if (got !== want) begin
          if (fail_count < 10)
            $display("%0t: key/tag/last/ovf expected %0d/%0d/%0b/%0b got %0d/%0d/%0b/%0b",
                     $realtime, want.key, want.tag, want.last, want.ovf,
                     got.key, got.tag, got.last, got.ovf);
          fail_count++;
        end
      end
    end
  end

  // Stimulus: reset, directed table, random batches, then drain.
  initial begin
    stim_row_t  row;
    key_style_t style;
    int         sent;
    int         n;
    int         i;
    bit         burst;
    bit         full_done;
    bit         overflow_done;
    rst           = 1'b1;
    start         = 1'b0;
    y_key         = '0;
    tag           = '0;
    last_in       = 1'b0;
    held_count    = 0;
    held_overflow = 1'b0;
    range_sp      = 0;
    fail_count    = 0;
    sent          = 0;
    full_done     = 1'b0;
    overflow_done = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    for (i = 0; i < DIRECTED_ROWS; i++) begin
      row = directed_rows[i];
      send_entry(row.key, row.tag, row.last, 1'b0);
      if (row.typed_exp) begin
        sorted_beats_due[sorted_beats_due.size() - 1] = row.exp_beat;
      end
    end

    // Mostly small batches; one exactly full presorted batch (worst-case sort)
    // and one that overflows, dropping a plain entry and the closing one.
    while (sent < RANDOM_ITEMS) begin
      style = key_style_t'($urandom_range(0, 4));
      burst = ($urandom_range(0, 3) == 0);
      if (!full_done && sent >= 60) begin
        n = SKQ_DEPTH;
        style = KEYS_RISING;
        full_done = 1'b1;
      end else if (!overflow_done && sent >= 180) begin
        n = SKQ_DEPTH + 2;
        overflow_done = 1'b1;
      end else if ($urandom_range(0, 3) != 0) begin
        n = $urandom_range(1, 8);
      end else begin
        n = $urandom_range(9, 24);
      end
      for (i = 0; i < n; i++)
        send_entry(pick_key(style, i), TAG_W'($urandom_range(0, 1023)), i == n - 1, burst);
      sent += n;
    end

    start <= 1'b0;
    while (sorted_beats_due.size() != 0 || busy) @(posedge clk);
    repeat (32) @(posedge clk);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog against a hung handshake or missing results.
  initial begin
    #2000000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

>>> files.f
rtl/skq_pkg.sv
rtl/skq_ram.sv
rtl/sprite_key_quicksort.sv
bench/tb_top.sv
